>>> rtl/twp_pkg.sv
`timescale 1ns / 1ps

package twp_pkg;

  // Batch capacity and derived index widths
  localparam int CAPACITY = 64;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int DW       = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store the incoming word, or mark overflow
    logic init;       // set up pointers for partitioning
    logic rd_cur;     // read entry at cursor
    logic rd_lt;      // less case: read entry at low pointer
    logic rd_gt;      // greater case: drop high pointer, read entry there
    logic wr_swp;     // write cursor data to swap address
    logic wr_cur;     // write swap data to cursor
    logic inc_cur;    // advance cursor
    logic emit_start; // rewind cursor for output
    logic clear;      // batch finished
  } twp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cmp_lt;     // read word below pivot
    logic cmp_gt;     // read word above pivot
    logic part_done;  // cursor reached high pointer
    logic emit_last;  // cursor sits on last stored entry
  } twp_sts_t;

endpackage

>>> rtl/twp_ctrl.sv
`timescale 1ns / 1ps

module twp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  twp_pkg::twp_sts_t sts,
  output twp_pkg::twp_cmd_t cmd
);
  import twp_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SW1  = 3'd3;
  localparam logic [2:0] S_SW2  = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_EOUT = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_EOUT);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.init  = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (sts.part_done) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_ERD;
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.cmp_lt) begin
          cmd.rd_lt = 1'b1;
          state_nxt = S_SW1;
        end else if (sts.cmp_gt) begin
          cmd.rd_gt = 1'b1;
          state_nxt = S_SW1;
        end else begin
          cmd.inc_cur = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_SW1: begin
        cmd.wr_swp = 1'b1;
        state_nxt  = S_SW2;
      end
      S_SW2: begin
        cmd.wr_cur = 1'b1;
        state_nxt  = S_RD;
      end
      S_ERD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_EOUT;
      end
      S_EOUT: begin
        if (!out_stall) begin
          if (sts.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            cmd.inc_cur = 1'b1;
            state_nxt   = S_ERD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/twp_dp.sv
`timescale 1ns / 1ps

module twp_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [twp_pkg::DW-1:0]   cfg_wdata,
  input  logic [twp_pkg::DW-1:0]   in_value,
  input  twp_pkg::twp_cmd_t        cmd,
  output twp_pkg::twp_sts_t        sts,
  output logic [twp_pkg::DW-1:0]   out_value_res,
  output logic                     out_last_res,
  output logic                     out_overflow
);
  import twp_pkg::*;

  logic [DW-1:0] store_r [CAPACITY];
  logic [DW-1:0] rd_a_r, rd_b_r;
  logic signed [DW-1:0] pivot_r, pivot_nxt;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] low_r, low_nxt;
  logic [CW-1:0] high_r, high_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] swp_r, swp_nxt;
  logic          lt_r, lt_nxt;
  logic          drop_r, drop_nxt;

  logic          full;
  logic [CW-1:0] high_m1;
  logic [AW-1:0] rd_b_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  assign full    = (fill_r == CW'(CAPACITY));
  assign high_m1 = high_r - CW'(1);

  // Status back to the controller
  assign sts.cmp_lt    = ($signed(rd_a_r) < pivot_r);
  assign sts.cmp_gt    = ($signed(rd_a_r) > pivot_r);
  assign sts.part_done = (cur_r >= high_r);
  assign sts.emit_last = ((cur_r + CW'(1)) == fill_r);

  assign out_value_res = rd_a_r;
  assign out_last_res  = sts.emit_last;
  assign out_overflow  = drop_r;

  // Pointer and batch bookkeeping
  always_comb begin
    pivot_nxt = cfg_we ? $signed(cfg_wdata) : pivot_r;
    fill_nxt  = fill_r;
    drop_nxt  = drop_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    cur_nxt   = cur_r;
    swp_nxt   = swp_r;
    lt_nxt    = lt_r;
    if (cmd.load) begin
      if (full) drop_nxt = 1'b1;
      else      fill_nxt = fill_r + CW'(1);
    end
    if (cmd.init) begin
      low_nxt  = '0;
      cur_nxt  = '0;
      high_nxt = full ? fill_r : fill_r + CW'(1);
    end
    if (cmd.rd_lt) begin
      swp_nxt = low_r[AW-1:0];
      lt_nxt  = 1'b1;
    end
    if (cmd.rd_gt) begin
      swp_nxt  = high_m1[AW-1:0];
      high_nxt = high_m1;
      lt_nxt   = 1'b0;
    end
    if (cmd.wr_cur && lt_r) begin
      low_nxt = low_r + CW'(1);
      cur_nxt = cur_r + CW'(1);
    end
    if (cmd.inc_cur)    cur_nxt = cur_r + CW'(1);
    if (cmd.emit_start) cur_nxt = '0;
    if (cmd.clear) begin
      fill_nxt = '0;
      drop_nxt = 1'b0;
      low_nxt  = '0;
      high_nxt = '0;
      cur_nxt  = '0;
    end
  end

  // Single write port: load, then the two halves of a swap
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_r[AW-1:0];
    wr_data = rd_b_r;
    if (cmd.load && !full) begin
      wr_en   = 1'b1;
      wr_addr = fill_r[AW-1:0];
      wr_data = in_value;
    end else if (cmd.wr_swp) begin
      wr_en   = 1'b1;
      wr_addr = swp_r;
      wr_data = rd_a_r;
    end else if (cmd.wr_cur) begin
      wr_en = 1'b1;
    end
  end

  assign rd_b_addr = cmd.rd_lt ? low_r[AW-1:0] : high_m1[AW-1:0];

  // Element store with registered reads
  always_ff @(posedge clk) begin
    if (wr_en) store_r[wr_addr] <= wr_data;
    if (cmd.rd_cur) rd_a_r <= store_r[cur_r[AW-1:0]];
    if (cmd.rd_lt || cmd.rd_gt) rd_b_r <= store_r[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r <= '0;
      fill_r  <= '0;
      drop_r  <= 1'b0;
      low_r   <= '0;
      high_r  <= '0;
      cur_r   <= '0;
      swp_r   <= '0;
      lt_r    <= 1'b0;
    end else begin
      pivot_r <= pivot_nxt;
      fill_r  <= fill_nxt;
      drop_r  <= drop_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      cur_r   <= cur_nxt;
      swp_r   <= swp_nxt;
      lt_r    <= lt_nxt;
    end
  end

endmodule

>>> rtl/three_way_partition_unit.sv
`timescale 1ns / 1ps
// Load: one word per cycle while in_stall is low; words with last low give no result.
// Partition: an equal step reads and compares (S_RD, S_CMP); a swap step adds S_SW1 and S_SW2,
//   the two writes of a swap through the single write port of the element store.
// Output: each result is a registered read, then the output word, held while out_stall is high.
// Reset (rst_n, synchronous, active low) clears pivot, counts and pointers.

module three_way_partition_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [twp_pkg::DW-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [twp_pkg::DW-1:0] in_value,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [twp_pkg::DW-1:0] out_value_res,
  output logic                   out_last_res,
  output logic                   out_overflow
);
  import twp_pkg::*;

  twp_cmd_t cmd;
  twp_sts_t sts;

  twp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  twp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res),
    .out_overflow  (out_overflow)
  );

endmodule

>>> rtl/twp_checker.sv
`timescale 1ns / 1ps

module twp_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   in_last,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [twp_pkg::DW-1:0] out_value_res,
  input logic                   out_last_res,
  input logic                   out_overflow
);

  // No input word taken while a batch is being output
  a_no_load_in_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during output");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_res)
      && $stable(out_last_res) && $stable(out_overflow))
    else $error("stalled result changed");

  // Output ends after the word marked last
  a_end_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_res |=> !out_valid && !in_stall)
    else $error("output continued after last word");

  // A word without last produces no result next cycle
  a_nonlast_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last |=> !out_valid && !in_stall)
    else $error("result after non-last input");

endmodule

bind three_way_partition_unit twp_checker u_twp_checker (.*);

>>> tb/sv/tb_three_way_partition_unit.sv
`timescale 1ns / 1ps

module tb_three_way_partition_unit;
  import twp_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RST_CYCLES    = 11;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_MAX    = 10;
  localparam int DIR_ROWS      = 21;
  localparam int PEND_DEPTH    = 256;

  localparam logic [DW-1:0] PIVOT_MIN = 32'h8000_0000;
  localparam logic [DW-1:0] PIVOT_MAX = 32'h7fff_ffff;
  localparam logic [DW-1:0] NEG_ONE   = 32'hffff_ffff;
  localparam logic [DW-1:0] NEG_TWO   = 32'hffff_fffe;
  localparam logic [DW-1:0] NEG_THREE = 32'hffff_fffd;

  // One emitted word of a partitioned batch
  typedef struct packed {
    logic [DW-1:0] value;
    logic          last;
    logic          ovf;
  } part_word_t;

  // Directed stimulus row; typed rows are single-word batches with a known result
  typedef struct packed {
    logic [DW-1:0] value;
    logic          last;
    logic          typed;
    logic [DW-1:0] want;
  } dir_row_t;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          cfg_we    = 1'b0;
  logic [DW-1:0] cfg_wdata = '0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  logic [DW-1:0] in_value  = '0;
  logic          in_last   = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [DW-1:0] out_value_res;
  logic          out_last_res;
  logic          out_overflow;

  // Predictor state
  logic [DW-1:0] pivot_copy = '0;
  logic [DW-1:0] elem_copy [CAPACITY];
  int            fill_cnt   = 0;
  logic          lost_words = 1'b0;

  // Expected words: ring with write and read counts
  part_word_t    pending_words [PEND_DEPTH];
  int            pend_wr    = 0;
  int            pend_rd    = 0;
  part_word_t    fresh_words [CAPACITY];
  int            fresh_cnt  = 0;
  part_word_t    head_word;
  int            err_count  = 0;
  int            cycle_cnt  = 0;
  int            hold_cnt   = 0;
  bit            gaps_on    = 1'b1;
  bit            hold_req   = 1'b0;

  // Pivot 0 from reset; single words first, then small mixed batches
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{32'd0,     1'b1, 1'b1, 32'd0},
    '{PIVOT_MIN, 1'b1, 1'b1, PIVOT_MIN},
    '{PIVOT_MAX, 1'b1, 1'b1, PIVOT_MAX},
    '{32'd5,     1'b0, 1'b0, 32'd0},
    '{NEG_THREE, 1'b0, 1'b0, 32'd0},
    '{32'd0,     1'b0, 1'b0, 32'd0},
    '{32'd7,     1'b0, 1'b0, 32'd0},
    '{NEG_ONE,   1'b0, 1'b0, 32'd0},
    '{32'd0,     1'b1, 1'b0, 32'd0},
    '{32'd0,     1'b0, 1'b0, 32'd0},
    '{32'd0,     1'b1, 1'b0, 32'd0},
    '{32'd3,     1'b0, 1'b0, 32'd0},
    '{32'd2,     1'b0, 1'b0, 32'd0},
    '{32'd1,     1'b1, 1'b0, 32'd0},
    '{NEG_ONE,   1'b0, 1'b0, 32'd0},
    '{NEG_TWO,   1'b1, 1'b0, 32'd0},
    '{PIVOT_MAX, 1'b0, 1'b0, 32'd0},
    '{PIVOT_MIN, 1'b0, 1'b0, 32'd0},
    '{32'd1,     1'b0, 1'b0, 32'd0},
    '{NEG_ONE,   1'b0, 1'b0, 32'd0},
    '{32'd0,     1'b1, 1'b0, 32'd0}
  };

  three_way_partition_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value_res(out_value_res),
    .out_last_res (out_last_res),
    .out_overflow (out_overflow)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Store one word; on last, run the flag partition and list the batch in order
  task automatic predict_flag_order(input logic [DW-1:0] v, input logic lst);
    int            lo;
    int            hi;
    int            cur;
    int            k;
    logic [DW-1:0] tmp;
    part_word_t    w;
    fresh_cnt = 0;
    if (fill_cnt < CAPACITY) begin
      elem_copy[fill_cnt] = v;
      fill_cnt++;
    end else begin
      lost_words = 1'b1;
    end
    if (lst) begin
      lo  = 0;
      hi  = fill_cnt;
      cur = 0;
      while (cur < hi) begin
        if ($signed(elem_copy[cur]) < $signed(pivot_copy)) begin
          tmp            = elem_copy[lo];
          elem_copy[lo]  = elem_copy[cur];
          elem_copy[cur] = tmp;
          lo++;
          cur++;
        end else if ($signed(elem_copy[cur]) > $signed(pivot_copy)) begin
          hi--;
          tmp            = elem_copy[hi];
          elem_copy[hi]  = elem_copy[cur];
          elem_copy[cur] = tmp;
        end else begin
          cur++;
        end
      end
      for (k = 0; k < fill_cnt; k++) begin
        w.value        = elem_copy[k];
        w.last         = (k == fill_cnt - 1);
        w.ovf          = lost_words;
        fresh_words[k] = w;
      end
      fresh_cnt  = fill_cnt;
      fill_cnt   = 0;
      lost_words = 1'b0;
    end
  endtask

  // Append one expected word to the ring
  task automatic queue_word(input part_word_t w);
    pending_words[pend_wr % PEND_DEPTH] = w;
    pend_wr++;
  endtask

  // Offer one word, wait for acceptance, then queue what it produces
  task automatic send_word(input logic [DW-1:0] v, input logic lst,
                           input logic typed, input logic [DW-1:0] want);
    part_word_t w;
    int         i;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    in_last  = lst;
    do @(posedge clk); while (in_stall);
    predict_flag_order(v, lst);
    if (typed) begin
      w.value = want;
      w.last  = 1'b1;
      w.ovf   = 1'b0;
      queue_word(w);
    end else begin
      for (i = 0; i < fresh_cnt; i++) queue_word(fresh_words[i]);
    end
  endtask

  // Values near the pivot as often as full-range ones, so equal runs occur, plus extremes
  function automatic logic [DW-1:0] pick_value(input logic [DW-1:0] around);
    logic [DW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5, 6, 7: v = around + DW'($urandom_range(0, 6)) - 32'd3;
      8:          v = PIVOT_MIN;
      default:    v = PIVOT_MAX;
    endcase
    return v;
  endfunction

  task automatic send_batch(input int len);
    int i;
    for (i = 0; i < len; i++)
      send_word(pick_value(pivot_copy), i == len - 1, 1'b0, '0);
  endtask

  // Small random batches until the word count is reached; always ends on a last word
  task automatic run_batches(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = $urandom_range(1, 12);
      send_batch(len);
      sent += len;
    end
  endtask

  // Pivot changes only once the block has drained
  task automatic write_pivot(input logic [DW-1:0] p);
    @(negedge clk);
    in_valid = 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = p;
    @(negedge clk);
    cfg_we     = 1'b0;
    pivot_copy = p;
  endtask

  task automatic note_fail(input string msg);
    err_count++;
    if (err_count <= REPORT_MAX) $display("%s", msg);
  endtask

  // Output checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pend_wr == pend_rd) begin
        note_fail($sformatf("unexpected word: value=%h last=%b ovf=%b",
                            out_value_res, out_last_res, out_overflow));
      end else begin
        head_word = pending_words[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (out_value_res !== head_word.value || out_last_res !== head_word.last ||
            out_overflow !== head_word.ovf)
          note_fail($sformatf("word mismatch: exp value=%h last=%b ovf=%b, got value=%h last=%b ovf=%b",
                              head_word.value, head_word.last, head_word.ovf,
                              out_value_res, out_last_res, out_overflow));
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        hold_cnt  = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(negedge clk);
          hold_cnt++;
        end
        out_stall = 1'b0;
        hold_req  = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows against the reset pivot
    foreach (dir_rows[i])
      send_word(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

    // lowest pivot; receiver holds off over a full batch, then an overflowing one is sent
    write_pivot(PIVOT_MIN);
    hold_req = 1'b1;
    send_batch(CAPACITY);
    send_batch(CAPACITY + 1);

    // highest pivot; overflow with two dropped words
    write_pivot(PIVOT_MAX);
    send_batch(CAPACITY + 2);
    run_batches(25);

    write_pivot($urandom());
    run_batches(70);

    // small pivot, no idling on either side
    write_pivot(NEG_THREE);
    gaps_on = 1'b0;
    run_batches(60);

    @(negedge clk);
    in_valid = 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pend_wr == pend_rd) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
